FILE: rtl/sfir_pkg.sv
package sfir_pkg;

  localparam int TAP_COUNT  = 5;
  localparam int REG_COUNT  = 5;
  localparam int HIST_DEPTH = TAP_COUNT - 1;
  localparam int NUM_COEF   = (TAP_COUNT < REG_COUNT) ? TAP_COUNT : REG_COUNT;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + $clog2(TAP_COUNT);
  localparam int FRAC_W   = 13;

  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(4 * REG_COUNT);
  localparam int IDX_W    = ADDR_W - 2;
  localparam int CIDX_W   = (NUM_COEF > 1) ? $clog2(NUM_COEF) : 1;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef coef_t [TAP_COUNT-1:0]      coef_vec_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  typedef struct packed {
    cnt_t credit;
    cnt_t fill;
  } sfir_stat_t;

  localparam coef_t COEF_RESET [REG_COUNT] = '{
    -16'sd1024, 16'sd2048, 16'sd6144, 16'sd2048, -16'sd1024
  };

  localparam acc_t FRAC_BIAS = acc_t'((1 << FRAC_W) - 1);

  // Divide by 2^FRAC_W with truncation toward zero and keep the low sample bits.
  function automatic sample_t trunc_q(acc_t a);
    acc_t b;
    b = a + (a[ACC_W-1] ? FRAC_BIAS : acc_t'(0));
    return b[FRAC_W +: SAMPLE_W];
  endfunction

endpackage

FILE: rtl/sfir_regs.sv
module sfir_regs import sfir_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output coef_vec_t         coef
);

  coef_t            coef_reg [NUM_COEF];
  logic [IDX_W-1:0] idx;
  logic             hit;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign hit    = (idx < IDX_W'(NUM_COEF));
  assign wr_en  = psel && penable && pwrite && hit;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        coef_reg[k] <= COEF_RESET[k];
      end
    end else if (wr_en) begin
      coef_reg[idx[CIDX_W-1:0]] <= pwdata[COEF_W-1:0];
    end
  end

  always_comb begin
    if (hit) begin
      prdata = DATA_W'(coef_reg[idx[CIDX_W-1:0]]);
    end else begin
      prdata = '0;
    end
  end

  // Taps without a register weigh zero.
  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_coef
    if (k < NUM_COEF) begin : g_reg
      assign coef[k] = coef_reg[k];
    end else begin : g_zero
      assign coef[k] = '0;
    end
  end

endmodule

FILE: rtl/sfir_lane.sv
module sfir_lane import sfir_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  sample_t   sample,
  input  coef_vec_t coef,
  output acc_t      sum
);

  sample_t history [HIST_DEPTH];
  sample_t tap     [TAP_COUNT];
  prod_t   prod    [TAP_COUNT];
  acc_t    sum_next;

  always_comb begin
    tap[0] = sample;
    for (int k = 1; k < TAP_COUNT; k++) begin
      tap[k] = history[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
        history[k] <= '0;
      end
    end else if (load) begin
      history[0] <= sample;
      for (int k = 1; k < HIST_DEPTH; k++) begin
        history[k] <= history[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < TAP_COUNT; k++) begin
        prod[k] <= coef[k] * tap[k];
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int k = 0; k < TAP_COUNT; k++) begin
      sum_next = sum_next + acc_t'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

endmodule

FILE: rtl/sfir_out.sv
module sfir_out import sfir_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_take,
  input  logic       out_take,
  input  acc_t       left_sum,
  input  acc_t       right_sum,
  output logic       busy,
  output logic       ready_out,
  output frame_t     head,
  output sfir_stat_t stat
);

  frame_t           mem [FIFO_DEPTH];
  logic             prod_vld;
  logic             sum_vld;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  cnt_t             credit;
  cnt_t             credit_next;
  cnt_t             fill;
  cnt_t             fill_next;
  frame_t           merged;

  assign merged.left  = trunc_q(left_sum);
  assign merged.right = trunc_q(right_sum);

  always_comb begin
    credit_next = credit;
    if (in_take && !out_take) begin
      credit_next = credit + cnt_t'(1);
    end else if (!in_take && out_take) begin
      credit_next = credit - cnt_t'(1);
    end
    fill_next = fill;
    if (sum_vld && !out_take) begin
      fill_next = fill + cnt_t'(1);
    end else if (!sum_vld && out_take) begin
      fill_next = fill - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      sum_vld  <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      credit   <= '0;
      fill     <= '0;
    end else begin
      prod_vld <= in_take;
      sum_vld  <= prod_vld;
      credit   <= credit_next;
      fill     <= fill_next;
      if (sum_vld) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (out_take) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_vld) begin
      mem[wr_ptr] <= merged;
    end
  end

  assign busy        = (credit == cnt_t'(FIFO_DEPTH));
  assign ready_out   = (fill != '0);
  assign head        = mem[rd_ptr];
  assign stat.credit = credit;
  assign stat.fill   = fill;

endmodule

FILE: rtl/stereo_five_tap_fir.sv
// Stereo five-tap FIR: each accepted transaction carries one left and one right sample, both
// channels are filtered with the same five Q2.13 coefficients written over the APB port, and
// one result transaction follows per input, in order. A new frame can be taken every clock
// cycle while input stall is low; a result passes through the product register, the sum
// register and the four-entry output queue before it appears. Input stall rises when four
// frames are in flight or queued; at one frame per cycle three are already in flight, so an
// output stall leaves room for one more frame before input stall rises.
module stereo_five_tap_fir import sfir_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  sample_t           left_sample,
  input  sample_t           right_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output sample_t           left_filtered,
  output sample_t           right_filtered
);

  coef_vec_t  coef;
  logic       in_take;
  logic       out_take;
  acc_t       left_sum;
  acc_t       right_sum;
  frame_t     head;
  sfir_stat_t stat;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  sfir_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  sfir_lane u_left (
    .clk    (clk),
    .rst    (rst),
    .load   (in_take),
    .sample (left_sample),
    .coef   (coef),
    .sum    (left_sum)
  );

  sfir_lane u_right (
    .clk    (clk),
    .rst    (rst),
    .load   (in_take),
    .sample (right_sample),
    .coef   (coef),
    .sum    (right_sum)
  );

  sfir_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .out_take  (out_take),
    .left_sum  (left_sum),
    .right_sum (right_sum),
    .busy      (in_stall),
    .ready_out (out_valid),
    .head      (head),
    .stat      (stat)
  );

  assign left_filtered  = head.left;
  assign right_filtered = head.right;

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    stat.credit <= cnt_t'(FIFO_DEPTH))
    else $error("in-flight count exceeds queue depth");

  a_fill_le_credit: assert property (@(posedge clk) disable iff (rst)
    stat.fill <= stat.credit)
    else $error("queued results exceed frames in flight");

  a_credit_inc: assert property (@(posedge clk) disable iff (rst)
    (in_take && !out_take) |=> (stat.credit == $past(stat.credit) + cnt_t'(1)))
    else $error("in-flight count missed an accepted frame");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_take && !out_valid) |-> ##3 out_valid)
    else $error("result did not appear three cycles after its frame");

endmodule
